[hdl/zebra_line_and_entry_detector_macros.svh]
// assertion macros used by the zebra line and entry detector checker
`ifndef ZEBRA_LINE_AND_ENTRY_DETECTOR_MACROS_SVH
`define ZEBRA_LINE_AND_ENTRY_DETECTOR_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define ZLED_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define ZLED_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/zled_pkg.sv]
// types and constants for the zebra line and entry detector
`timescale 1ns / 1ps

package zled_pkg;

    // frame geometry
    localparam int ROWS = 120;
    localparam int COLS = 188;

    // register reset values
    localparam logic [7:0] THRESHOLD_RESET = 8'd130;
    localparam logic [6:0] MIN_ENTRY_RESET = 7'd20;

    // entry row must lie more than this far below the scan top row
    localparam logic [7:0] ENTRY_MARGIN = 8'd5;
    // counting runs only on this fork count
    localparam logic [7:0] COUNT_FORKS  = 8'd2;
    localparam logic [7:0] COUNT_MAX    = 8'd255;

    // configuration register indexes
    localparam int          CFG_IDX_W     = 1;
    localparam logic [0:0]  CFG_THRESHOLD = 1'd0;
    localparam logic [0:0]  CFG_MIN_ENTRY = 1'd1;
    localparam int          CFG_DATA_W    = 8;

    // one pixel with its row-level context
    typedef struct packed {
        logic [6:0] row;
        logic [7:0] column;
        logic       pixel_white;
        logic [7:0] left_bound;
        logic [7:0] right_bound;
        logic       left_edge_found;
        logic [6:0] scan_top_row;
        logic [7:0] fork_count;
        logic       frame_end;
    } t_pixel_item;

    // per-frame result
    typedef struct packed {
        logic       zebra_seen;
        logic       home_entry;
        logic [6:0] entry_row;
        logic [7:0] transition_total;
    } t_result_item;

endpackage

[hdl/zebra_line_and_entry_detector.sv]
// top level: zebra crossing transition counter and home-entry row finder
`timescale 1ns / 1ps

// Takes one binary pixel per cycle in raster order, while the input side is not
// stalled, and returns one result per frame, on the pixel flagged frame_end. Each
// pixel is first captured in an input register; when it leaves that register, the
// per-frame state and the result register are updated from it, and the result
// is transferred out from the result register. The block sustains one pixel per
// cycle while the input side is not stalled.
// The input side stalls only when a frame_end pixel waits in the input register
// while the previous result has not been taken. Configuration writes must be
// made while no frame is in progress.
module zebra_line_and_entry_detector
    import zled_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // pixel channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_pixel_item           i_in_data,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_result_item          o_out_data,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration
    logic [7:0] r_threshold;
    logic [6:0] r_min_entry;

    // input register
    logic        r_in_vld, n_in_vld;
    t_pixel_item r_in,     n_in;

    // result register
    logic         r_out_vld, n_out_vld;
    t_result_item r_out,     n_out;

    // frame state
    logic       r_prev_white, n_prev_white;
    logic [7:0] r_count,      n_count;
    logic       r_frozen,     n_frozen;
    logic [1:0] r_history,    n_history;
    logic [6:0] r_first_row,  n_first_row;
    logic       r_match,      n_match;
    logic       r_above_min,  n_above_min;
    logic       r_bottom,     n_bottom;

    // sticky state
    logic       r_zebra,      n_zebra;
    logic       r_home,       n_home;
    logic [6:0] r_entry_row,  n_entry_row;

    logic out_free;
    logic fire;
    logic in_take;

    // stage control
    assign out_free   = !r_out_vld || !i_out_stall;
    assign fire       = r_in_vld && (!r_in.frame_end || out_free);
    assign o_in_stall = r_in_vld && !fire;
    assign in_take    = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
            r_min_entry <= MIN_ENTRY_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD: r_threshold <= i_cfg_data[7:0];
                CFG_MIN_ENTRY: r_min_entry <= i_cfg_data[6:0];
                default:       r_threshold <= r_threshold;
            endcase
        end
    end

    // input register load
    always_comb begin
        n_in     = r_in;
        n_in_vld = r_in_vld;
        if (in_take) begin
            n_in     = i_in_data;
            n_in_vld = 1'b1;
        end else if (fire) begin
            n_in_vld = 1'b0;
        end
    end

    // per-pixel update of frame and sticky state
    logic       counted_row;
    logic       row_in_frame;
    logic       row_end;
    logic [7:0] prev_col;
    logic       transition;
    logic [7:0] count_inc;
    logic       freeze_now;
    logic       is_candidate;
    logic       zebra_now;
    logic       bottom_now;
    logic       match_now;
    logic [6:0] first_now;
    logic       above_now;

    always_comb begin
        row_in_frame = ({1'b0, r_in.row} < 8'(ROWS));
        counted_row  = (r_in.fork_count == COUNT_FORKS) && (r_in.row >= r_in.scan_top_row)
                       && row_in_frame;
        row_end      = (r_in.column == 8'(COLS - 1)) || r_in.frame_end;
        prev_col     = r_in.column - 8'd1;

        // white at c-1, black at c, with c-1 inside the bounds
        transition = counted_row && !r_frozen && (r_in.column != 8'd0)
                     && (prev_col >= r_in.left_bound) && (prev_col < r_in.right_bound)
                     && r_prev_white && !r_in.pixel_white;
        count_inc  = (transition && (r_count != COUNT_MAX)) ? r_count + 8'd1 : r_count;

        freeze_now = row_end && counted_row && !r_frozen && (count_inc >= r_threshold);
        zebra_now  = r_zebra || freeze_now;

        // edge present with the two rows above it missing
        is_candidate = row_end && row_in_frame && r_in.left_edge_found && (r_history == 2'b00)
                       && ({1'b0, r_in.row} > ({1'b0, r_in.scan_top_row} + ENTRY_MARGIN));
        match_now  = r_match || is_candidate;
        first_now  = (is_candidate && !r_match) ? r_in.row : r_first_row;
        above_now  = r_above_min || (is_candidate && (r_in.row > r_min_entry));
        bottom_now = (row_end && row_in_frame && ({1'b0, r_in.row} == 8'(ROWS - 1)))
                     ? r_in.left_edge_found : r_bottom;

        n_prev_white = r_prev_white;
        n_count      = r_count;
        n_frozen     = r_frozen;
        n_history    = r_history;
        n_first_row  = r_first_row;
        n_match      = r_match;
        n_above_min  = r_above_min;
        n_bottom     = r_bottom;
        n_zebra      = r_zebra;
        n_home       = r_home;
        n_entry_row  = r_entry_row;

        if (fire) begin
            n_prev_white = r_in.pixel_white;
            n_count      = count_inc;
            n_frozen     = r_frozen || freeze_now;
            n_zebra      = zebra_now;
            n_first_row  = first_now;
            n_match      = match_now;
            n_above_min  = above_now;
            n_bottom     = bottom_now;
            if (row_end) begin
                n_history = {r_history[0], r_in.left_edge_found};
            end
            if (r_in.frame_end) begin
                // commit the entry row, then start a fresh frame
                if (zebra_now && bottom_now && match_now) begin
                    n_entry_row = first_now;
                    if (above_now) begin
                        n_home = 1'b1;
                    end
                end
                n_prev_white = 1'b0;
                n_count      = 8'd0;
                n_frozen     = 1'b0;
                n_history    = 2'b00;
                n_first_row  = 7'd0;
                n_match      = 1'b0;
                n_above_min  = 1'b0;
                n_bottom     = 1'b0;
            end
        end
    end

    // result register
    always_comb begin
        n_out     = r_out;
        n_out_vld = r_out_vld && i_out_stall;
        if (fire && r_in.frame_end) begin
            n_out_vld              = 1'b1;
            n_out.zebra_seen       = zebra_now;
            n_out.home_entry       = (zebra_now && bottom_now && match_now && above_now)
                                     || r_home;
            n_out.entry_row        = (zebra_now && bottom_now && match_now)
                                     ? first_now : r_entry_row;
            n_out.transition_total = count_inc;
        end
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_prev_white <= 1'b0;
            r_count      <= 8'd0;
            r_frozen     <= 1'b0;
            r_history    <= 2'b00;
            r_first_row  <= 7'd0;
            r_match      <= 1'b0;
            r_above_min  <= 1'b0;
            r_bottom     <= 1'b0;
            r_zebra      <= 1'b0;
            r_home       <= 1'b0;
            r_entry_row  <= 7'd0;
        end else begin
            r_in_vld     <= n_in_vld;
            r_out_vld    <= n_out_vld;
            r_prev_white <= n_prev_white;
            r_count      <= n_count;
            r_frozen     <= n_frozen;
            r_history    <= n_history;
            r_first_row  <= n_first_row;
            r_match      <= n_match;
            r_above_min  <= n_above_min;
            r_bottom     <= n_bottom;
            r_zebra      <= n_zebra;
            r_home       <= n_home;
            r_entry_row  <= n_entry_row;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_out <= n_out;
    end

endmodule

[hdl/zled_checker.sv]
// port-level checker for the zebra line and entry detector, with its bind
`timescale 1ns / 1ps
`include "zebra_line_and_entry_detector_macros.svh"

module zled_checker
    import zled_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input t_result_item          o_out_data
);

    // a stalled result stays put
    `ZLED_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_data), "result changed while stalled")

    // home entry is only raised after a zebra crossing
    `ZLED_ASSERT_IMPLY(a_home_needs_zebra, o_out_valid && o_out_data.home_entry,
        o_out_data.zebra_seen, "home entry without zebra")

    // the pixel side only backs up behind a stalled result
    `ZLED_ASSERT_IMPLY(a_stall_cause, o_in_stall, o_out_valid && i_out_stall,
        "input stalled with result side free")

    // the entry row is always a row of the frame
    `ZLED_ASSERT_IMPLY(a_entry_in_frame, o_out_valid,
        {1'b0, o_out_data.entry_row} <= 8'(ROWS - 1), "entry row outside frame")

endmodule

bind zebra_line_and_entry_detector zled_checker u_zled_checker (.*);

[tb/tb_top.sv]
// testbench for the zebra line and entry detector: pixel frames checked against a predictor
`timescale 1ns / 1ps

module tb_top;
    import zled_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 300;
    localparam int SAT_PIXELS    = 530;
    localparam t_result_item NO_RESULT = '0;

    // one row of the directed stimulus list
    typedef struct packed {
        t_pixel_item  px;
        logic         fixed_exp;
        t_result_item res;
    } t_directed_row;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_pixel_item           in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_result_item          out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // register copies held by the predictor
    logic [7:0] thr_reg;
    logic [6:0] min_row_reg;

    // predictor state: per frame and sticky
    logic       prev_white;
    logic [7:0] trans_cnt;
    logic       frozen;
    logic       zebra;
    logic       home;
    logic [6:0] entry_row;
    logic [1:0] edge_hist;
    logic [6:0] cand_row;
    logic       cand_seen;
    logic       cand_above_min;
    logic       bottom_edge;

    t_result_item frame_results_due[$];
    int mismatches  = 0;
    int sent_pixels = 0;
    int cycle_count = 0;
    bit tx_burst    = 1'b0;
    bit hold_req    = 1'b0;
    int hold_left   = 0;
    int stall_left  = 0;
    int calm_left   = 0;

    zebra_line_and_entry_detector i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // 20 ns clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", CYCLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic t_pixel_item mk_px(int row, int col, int white, int lb, int rb,
                                          int edge_f, int top, int forks, int fend);
        t_pixel_item p;
        p.row             = 7'(row);
        p.column          = 8'(col);
        p.pixel_white     = 1'(white);
        p.left_bound      = 8'(lb);
        p.right_bound     = 8'(rb);
        p.left_edge_found = 1'(edge_f);
        p.scan_top_row    = 7'(top);
        p.fork_count      = 8'(forks);
        p.frame_end       = 1'(fend);
        return p;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // per-frame state clears after each frame end
    task automatic clear_frame_state();
        prev_white     = 1'b0;
        trans_cnt      = '0;
        frozen         = 1'b0;
        edge_hist      = '0;
        cand_row       = '0;
        cand_seen      = 1'b0;
        cand_above_min = 1'b0;
        bottom_edge    = 1'b0;
    endtask

    task automatic reset_detector();
        thr_reg     = THRESHOLD_RESET;
        min_row_reg = MIN_ENTRY_RESET;
        zebra       = 1'b0;
        home        = 1'b0;
        entry_row   = '0;
        clear_frame_state();
    endtask

    // one pixel through the detector; done is set when a frame result comes out
    task automatic advance_detector(input t_pixel_item p, output bit done,
                                    output t_result_item res);
        bit         counted;
        bit         row_end;
        logic [7:0] prev_col;
        counted = (p.fork_count == COUNT_FORKS) && (p.row >= p.scan_top_row)
                  && (int'(p.row) < ROWS);
        row_end = (int'(p.column) == COLS - 1) || p.frame_end;

        // white-to-black transition inside the bounds, never closed at column zero
        if (counted && !frozen && p.column >= 8'd1) begin
            prev_col = p.column - 8'd1;
            if (prev_col >= p.left_bound && prev_col < p.right_bound && prev_white
                && !p.pixel_white && trans_cnt < COUNT_MAX)
                trans_cnt++;
        end
        prev_white = p.pixel_white;

        // row-level checks on the last pixel of a row
        if (row_end) begin
            if (counted && !frozen && trans_cnt >= thr_reg) begin
                frozen = 1'b1;
                zebra  = 1'b1;
            end
            if (int'(p.row) < ROWS) begin
                if (p.left_edge_found && edge_hist == 2'b00
                    && int'(p.row) > int'(p.scan_top_row) + int'(ENTRY_MARGIN)) begin
                    if (!cand_seen) begin
                        cand_seen = 1'b1;
                        cand_row  = p.row;
                    end
                    if (p.row > min_row_reg)
                        cand_above_min = 1'b1;
                end
                if (int'(p.row) == ROWS - 1)
                    bottom_edge = p.left_edge_found;
            end
            edge_hist = {edge_hist[0], p.left_edge_found};
        end

        // frame result
        done = p.frame_end;
        res  = '0;
        if (p.frame_end) begin
            if (zebra && bottom_edge && cand_seen) begin
                entry_row = cand_row;
                if (cand_above_min)
                    home = 1'b1;
            end
            res.zebra_seen       = zebra;
            res.home_entry       = home;
            res.entry_row        = entry_row;
            res.transition_total = trans_cnt;
            clear_frame_state();
        end
    endtask

    function automatic int tx_gap();
        int r;
        if (tx_burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // offer one pixel, wait for its transfer, then record what it should produce
    task automatic send_pixel(input t_pixel_item p, input bit fixed_exp,
                              input t_result_item fixed_res);
        bit           done;
        t_result_item res;
        int           gap;
        in_valid <= 1'b1;
        in_data  <= p;
        do
            @(posedge clk);
        while (in_stall);
        sent_pixels++;
        advance_detector(p, done, res);
        if (done)
            frame_results_due.push_back(fixed_exp ? fixed_res : res);
        gap = tx_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop sending and let every pending result come out
    task automatic wait_for_results();
        int waited;
        in_valid <= 1'b0;
        waited = 0;
        while (frame_results_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (frame_results_due.size() != 0)
            report_mismatch("results never delivered", 0, frame_results_due.size());
    endtask

    // both registers, write enable held across the two writes
    task automatic set_config(input logic [7:0] thr_v, input logic [7:0] min_v);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_THRESHOLD;
        cfg_data  <= thr_v;
        @(posedge clk);
        thr_reg = thr_v;
        cfg_index <= CFG_MIN_ENTRY;
        cfg_data  <= min_v;
        @(posedge clk);
        min_row_reg = min_v[6:0];
        cfg_we <= 1'b0;
    endtask

    // random frames: consecutive rows with a few pixels each, some noise pixels
    task automatic run_frames(input int min_items, input int min_frames);
        int         start;
        int         frames;
        int         n_rows;
        int         first_row;
        int         top;
        int         lb;
        int         rb;
        int         n_pix;
        int         col;
        int         row;
        bit         edge_f;
        bit         end_row;
        bit         end_frame;
        logic [7:0] forks;
        start  = sent_pixels;
        frames = 0;
        while (sent_pixels - start < min_items || frames < min_frames) begin
            tx_burst  = ($urandom_range(0, 3) == 0);
            n_rows    = $urandom_range(1, 6);
            first_row = ($urandom_range(0, 3) != 0) ? ROWS - n_rows : $urandom_range(0, 127);
            top = ($urandom_range(0, 9) != 0) ? first_row - $urandom_range(0, 10)
                                              : $urandom_range(0, 127);
            if (top < 0)
                top = 0;
            forks = ($urandom_range(0, 4) != 0) ? COUNT_FORKS : 8'($urandom);
            for (int r = 0; r < n_rows; r++) begin
                row = first_row + r;
                lb  = $urandom_range(0, 60);
                rb  = ($urandom_range(0, 9) != 0) ? $urandom_range(lb, COLS - 1)
                                                  : $urandom_range(0, 255);
                edge_f = (row == ROWS - 1) ? ($urandom_range(0, 4) != 0)
                                           : 1'($urandom_range(0, 1));
                n_pix  = ($urandom_range(0, 11) != 0) ? $urandom_range(1, 4)
                                                      : $urandom_range(10, 30);
                col = $urandom_range(0, 3);
                for (int k = 0; k < n_pix; k++) begin
                    // stray pixel with any field value
                    if ($urandom_range(0, 24) == 0)
                        send_pixel(mk_px($urandom_range(0, 127), $urandom_range(0, 255),
                                         $urandom_range(0, 1), $urandom_range(0, 255),
                                         $urandom_range(0, 255), $urandom_range(0, 1),
                                         $urandom_range(0, 127), $urandom_range(0, 255),
                                         int'($urandom_range(0, 7) == 0)), 1'b0, NO_RESULT);
                    end_row   = (k == n_pix - 1);
                    end_frame = end_row && (r == n_rows - 1);
                    if (end_row && (!end_frame || $urandom_range(0, 1)))
                        col = COLS - 1;
                    send_pixel(mk_px(row, col,
                                     int'(((k % 2) == 0) ^ ($urandom_range(0, 7) == 0)),
                                     lb, rb, int'(edge_f), top, int'(forks), int'(end_frame)),
                               1'b0, NO_RESULT);
                    col = col + $urandom_range(1, 8);
                    if (col > COLS - 2)
                        col = COLS - 2;
                end
            end
            frames++;
        end
    endtask

    // compare one result transfer with the oldest expected one
    task automatic check_result(input t_result_item got);
        t_result_item want;
        if (frame_results_due.size() == 0) begin
            report_mismatch("result with none pending", 32'(got), 0);
            return;
        end
        want = frame_results_due.pop_front();
        if (got.zebra_seen !== want.zebra_seen)
            report_mismatch("zebra_seen", 32'(got.zebra_seen), 32'(want.zebra_seen));
        if (got.home_entry !== want.home_entry)
            report_mismatch("home_entry", 32'(got.home_entry), 32'(want.home_entry));
        if (got.entry_row !== want.entry_row)
            report_mismatch("entry_row", 32'(got.entry_row), 32'(want.entry_row));
        if (got.transition_total !== want.transition_total)
            report_mismatch("transition_total", 32'(got.transition_total),
                            32'(want.transition_total));
    endtask

    // result side: check transfers, stall at random or for a long hold-off
    always @(posedge clk) begin : result_side
        int roll;
        if (rst_n && out_valid && !out_stall)
            check_result(out_data);
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
            if (calm_left > 0) begin
                calm_left--;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 4)
                    calm_left = $urandom_range(30, 80);
                else if (roll < 24)
                    stall_left = $urandom_range(1, 3);
                else if (roll < 27)
                    stall_left = $urandom_range(20, 50);
            end
        end
    end

    initial begin : stimulus
        t_directed_row directed_rows[$];
        logic [7:0]    thr_v;
        reset_detector();

        // after reset, a lone frame end gives an all-zero result
        directed_rows.push_back({mk_px(0, 0, 0, 0, 0, 0, 0, 0, 1), 1'b1, NO_RESULT});
        // all fields at their top values, row out of range, no counting
        directed_rows.push_back({mk_px(127, 255, 1, 255, 255, 1, 127, 255, 1), 1'b1, NO_RESULT});
        // white then black at column zero: no transition
        directed_rows.push_back({mk_px(10, 5, 1, 0, 187, 0, 0, 2, 0), 1'b0, NO_RESULT});
        directed_rows.push_back({mk_px(10, 0, 0, 0, 187, 0, 0, 2, 0), 1'b0, NO_RESULT});
        // transition starting on the left bound counts
        directed_rows.push_back({mk_px(10, 20, 1, 20, 40, 0, 0, 2, 0), 1'b0, NO_RESULT});
        directed_rows.push_back({mk_px(10, 21, 0, 20, 40, 0, 0, 2, 0), 1'b0, NO_RESULT});
        // transition starting on the right bound does not
        directed_rows.push_back({mk_px(10, 40, 1, 20, 40, 0, 0, 2, 0), 1'b0, NO_RESULT});
        directed_rows.push_back({mk_px(10, 41, 0, 20, 40, 0, 0, 2, 0), 1'b0, NO_RESULT});
        // left of the left bound does not
        directed_rows.push_back({mk_px(10, 18, 1, 20, 40, 0, 0, 2, 0), 1'b0, NO_RESULT});
        directed_rows.push_back({mk_px(10, 19, 0, 20, 40, 0, 0, 2, 0), 1'b0, NO_RESULT});
        // row end on the last column
        directed_rows.push_back({mk_px(10, 187, 0, 0, 187, 0, 0, 2, 0), 1'b0, NO_RESULT});
        // row above the scan top row
        directed_rows.push_back({mk_px(11, 3, 1, 0, 187, 1, 50, 2, 0), 1'b0, NO_RESULT});
        directed_rows.push_back({mk_px(11, 4, 0, 0, 187, 1, 50, 2, 0), 1'b0, NO_RESULT});
        // fork count other than two
        directed_rows.push_back({mk_px(12, 3, 1, 0, 187, 0, 0, 3, 0), 1'b0, NO_RESULT});
        directed_rows.push_back({mk_px(12, 4, 0, 0, 187, 0, 0, 3, 0), 1'b0, NO_RESULT});
        directed_rows.push_back({mk_px(12, 187, 0, 0, 187, 0, 0, 3, 0), 1'b0, NO_RESULT});
        // first row past the last image row is not counted
        directed_rows.push_back({mk_px(120, 3, 1, 0, 187, 1, 0, 2, 0), 1'b0, NO_RESULT});
        directed_rows.push_back({mk_px(120, 4, 0, 0, 187, 1, 0, 2, 1), 1'b0, NO_RESULT});
        // bottom row, widest bounds, row end by frame end
        directed_rows.push_back({mk_px(119, 1, 1, 0, 255, 1, 0, 2, 0), 1'b0, NO_RESULT});
        directed_rows.push_back({mk_px(119, 255, 0, 0, 255, 1, 0, 2, 1), 1'b0, NO_RESULT});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows under the reset register values
        foreach (directed_rows[i])
            send_pixel(directed_rows[i].px, directed_rows[i].fixed_exp, directed_rows[i].res);
        wait_for_results();

        // threshold out of reach of short frames
        set_config(8'd200, 8'd127);
        run_frames(30, 3);
        wait_for_results();

        // one long row saturates the count, which then freezes at the row end
        set_config(COUNT_MAX, 8'd127);
        tx_burst = 1'b0;
        for (int k = 0; k < SAT_PIXELS; k++)
            send_pixel(mk_px(50, 1 + k % (COLS - 2), int'((k % 2) == 0), 0, COLS - 1, 0, 0,
                             int'(COUNT_FORKS), 0), 1'b0, NO_RESULT);
        send_pixel(mk_px(50, COLS - 1, 0, 0, COLS - 1, 0, 0, int'(COUNT_FORKS), 0),
                   1'b0, NO_RESULT);
        send_pixel(mk_px(51, 1, 1, 0, COLS - 1, 0, 0, int'(COUNT_FORKS), 0), 1'b0, NO_RESULT);
        send_pixel(mk_px(51, 2, 0, 0, COLS - 1, 0, 0, int'(COUNT_FORKS), 0), 1'b0, NO_RESULT);
        send_pixel(mk_px(51, 3, 0, 0, COLS - 1, 0, 0, int'(COUNT_FORKS), 1), 1'b0, NO_RESULT);
        run_frames(30, 3);
        wait_for_results();

        // lowest settings, with a result-side hold-off while one-pixel frames pile up
        set_config(8'd0, 8'd0);
        tx_burst = 1'b1;
        hold_req = 1'b1;
        for (int k = 0; k < 12; k++)
            send_pixel(mk_px($urandom_range(0, ROWS - 1), COLS - 1, $urandom_range(0, 1), 0,
                             COLS - 1, $urandom_range(0, 1), 0, int'(COUNT_FORKS), 1),
                       1'b0, NO_RESULT);
        run_frames(30, 3);
        wait_for_results();

        // random settings, mostly small thresholds so the freeze shows up
        repeat (3) begin
            thr_v = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(1, 15)) : 8'($urandom);
            set_config(thr_v, 8'($urandom));
            run_frames(30, 3);
            wait_for_results();
        end

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/zled_pkg.sv
hdl/zebra_line_and_entry_detector.sv
hdl/zled_checker.sv
tb/tb_top.sv
